// ===== design/sbb_pkg.sv =====
// Shared types, constants and register codes of the separable box blur.
package sbb_pkg;

  // Defaults for the size parameters of the top level
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_RADIUS = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int RADIUS_W   = 4;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [RADIUS_W-1:0] RST_RADIUS = 4'd9;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd1;

  // One ARGB pixel as stored in both memories
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } px_t;

endpackage

// ===== design/separable_box_blur_argb.sv =====
// Separable box blur of one ARGB frame with clamp-to-edge borders: top level.
//
// Pixels enter in raster order; output pixel j leaves on input word
// j + R*W + R, and words after the W*H pixels of a frame only drain it.
// R, W and H are sampled on the first word of each frame. One word is taken
// at a time: it passes through the control states (plus a setup state on the
// first word of a frame) and a check state. For every horizontal column it
// completes it sweeps the read port of the row window RAM, runs the serial
// divider and writes the row store. When it yields a result it sweeps the
// read port of the row store RAM, runs the divider and waits for the output
// register, longer while the output word is held. A row-end word also walks
// on through up to R more horizontal columns. Both RAMs start undefined and
// need no clearing.
module separable_box_blur_argb import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            alpha_in_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            alpha_out_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic                  frame_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RK     = 2 * MAX_RADIUS + 2;
  localparam int PTR_W  = $clog2(RK);
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int R_W    = $clog2(MAX_RADIUS + 1);
  localparam int TOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int T_W    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS
                                 + MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int POS_W  = $clog2(MAX_WIDTH + MAX_HEIGHT + MAX_RADIUS + 1) + 1;
  localparam int SUM_W  = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int DIV_W  = $clog2(2 * MAX_RADIUS + 2);
  localparam int HP_DEP = RK * (2 ** XW);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_PIX, S_SWEEP, S_SWLAST, S_DSTART,
    S_DIV, S_HWR, S_VCHK, S_VOUT, S_FIN
  } state_e;

  // Configuration registers
  logic [RADIUS_W-1:0] reg_radius_q;
  logic [WIDTH_W-1:0]  reg_width_q;
  logic [HEIGHT_W-1:0] reg_height_q;

  state_e state_q;

  // Frame geometry latched at the first word
  logic [R_W-1:0]   cur_r_q;
  logic [W_W-1:0]   cur_w_q;
  logic [H_W-1:0]   cur_h_q;
  logic [TOT_W-1:0] total_q;
  logic [T_W-1:0]   lag_q;

  // Frame position
  logic [T_W-1:0]   t_q;
  logic [XW-1:0]    k_q;
  logic [PTR_W-1:0] wp_q;
  logic [PTR_W-1:0] rowp_q;
  logic [XW-1:0]    x_q;
  logic [H_W-1:0]   y_q;
  logic [PTR_W-1:0] yp_q;
  logic [TOT_W-1:0] j_q;

  // Horizontal column walk
  logic [XW-1:0]           hc_q;
  logic                    row_end_q;
  logic signed [POS_W-1:0] hs_pos_q;
  logic [PTR_W-1:0]        hs_ptr_q;

  // Read sweep
  logic                    hv_q;
  logic signed [POS_W-1:0] sw_pos_q;
  logic [PTR_W-1:0]        sw_ptr_q;
  logic [R_W:0]            sw_left_q;
  logic                    rd_vld_q;
  logic [3:0][SUM_W-1:0]   acc_q;

  px_t pix_q;
  px_t out_px_q;
  logic out_valid_q;
  logic out_fe_q;

  // Memory and divider connections
  px_t                     rw_rdata;
  px_t                     hp_rdata;
  px_t                     rd_px;
  logic                    rw_we;
  logic                    hp_we;
  logic [PTR_W+XW-1:0]     hp_waddr;
  logic [PTR_W+XW-1:0]     hp_raddr;
  logic                    div_start;
  logic                    div_done;
  px_t                     div_quot;

  // Combinational helpers
  logic                    in_frame;
  logic                    emit;
  logic                    last_px;
  logic signed [POS_W-1:0] r_s;
  logic signed [POS_W-1:0] pos_next;
  logic signed [POS_W-1:0] lim;
  logic                    adv;
  logic [XW-1:0]           hc_start;
  logic signed [POS_W-1:0] h_pos;
  logic [PTR_W-1:0]        h_ptr;
  logic signed [POS_W-1:0] v_pos;
  logic [PTR_W-1:0]        v_ptr;
  logic                    k_last;
  logic                    k_ge_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (32'(p) == RK - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0] p,
                                               input logic [R_W:0] d);
    logic [PTR_W:0] s;
    s = (PTR_W + 1)'(p) + (PTR_W + 1)'(RK) - (PTR_W + 1)'(d);
    if (32'(s) >= RK) begin
      s = s - (PTR_W + 1)'(RK);
    end
    return s[PTR_W-1:0];
  endfunction

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_radius_q <= RST_RADIUS;
      reg_width_q  <= RST_WIDTH;
      reg_height_q <= RST_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIUS: reg_radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_WIDTH:  reg_width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: reg_height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Sweep position, clamping and start points
  always_comb begin
    in_frame = t_q < T_W'(total_q);
    emit     = t_q >= lag_q;
    last_px  = (TOT_W'(j_q + 1'b1) == total_q);
    r_s      = POS_W'(cur_r_q);
    pos_next = sw_pos_q + POS_W'(1);
    lim      = hv_q ? POS_W'(cur_h_q) - POS_W'(1) : POS_W'(cur_w_q) - POS_W'(1);
    adv      = !pos_next[POS_W-1] && (pos_next != '0) && (pos_next <= lim);
    k_last   = W_W'(k_q) == cur_w_q - 1'b1;
    k_ge_r   = 32'(k_q) >= 32'(cur_r_q);
    if (k_last && !k_ge_r) begin
      hc_start = '0;
    end else begin
      hc_start = XW'(32'(k_q) - 32'(cur_r_q));
    end
    h_pos = POS_W'(hc_start) - r_s;
    h_ptr = h_pos[POS_W-1] ? '0 : ptr_sub(wp_q, {cur_r_q, 1'b0});
    v_pos = POS_W'(y_q) - r_s;
    v_ptr = v_pos[POS_W-1] ? '0 : ptr_sub(yp_q, (R_W + 1)'(cur_r_q));
  end

  // Memory controls
  always_comb begin
    rw_we     = (state_q == S_PIX) && in_frame;
    hp_we     = (state_q == S_HWR);
    hp_waddr  = {rowp_q, hc_q};
    hp_raddr  = {sw_ptr_q, x_q};
    div_start = (state_q == S_DSTART);
    rd_px     = hv_q ? hp_rdata : rw_rdata;
  end

  sbb_ram #(
    .WIDTH ($bits(px_t)),
    .DEPTH (RK)
  ) u_row_window (
    .clk_i   (clk_i),
    .we_i    (rw_we),
    .waddr_i (wp_q),
    .wdata_i (pix_q),
    .raddr_i (sw_ptr_q),
    .rdata_o (rw_rdata)
  );

  sbb_ram #(
    .WIDTH ($bits(px_t)),
    .DEPTH (HP_DEP)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (hp_we),
    .waddr_i (hp_waddr),
    .wdata_i (div_quot),
    .raddr_i (hp_raddr),
    .rdata_o (hp_rdata)
  );

  sbb_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (acc_q),
    .divisor_i (DIV_W'({cur_r_q, 1'b1})),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Sequencer: one word at a time through both passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_r_q     <= '0;
      cur_w_q     <= W_W'(1);
      cur_h_q     <= H_W'(1);
      total_q     <= TOT_W'(1);
      lag_q       <= '0;
      t_q         <= '0;
      k_q         <= '0;
      wp_q        <= '0;
      rowp_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      yp_q        <= '0;
      j_q         <= '0;
      hc_q        <= '0;
      row_end_q   <= 1'b0;
      hs_pos_q    <= '0;
      hs_ptr_q    <= '0;
      hv_q        <= 1'b0;
      sw_pos_q    <= '0;
      sw_ptr_q    <= '0;
      sw_left_q   <= '0;
      rd_vld_q    <= 1'b0;
      acc_q       <= '0;
      pix_q       <= '0;
      out_px_q    <= '0;
      out_valid_q <= 1'b0;
      out_fe_q    <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SWEEP);
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // accumulate the word read in the previous cycle
      if (rd_vld_q) begin
        acc_q[0] <= acc_q[0] + SUM_W'(rd_px.a);
        acc_q[1] <= acc_q[1] + SUM_W'(rd_px.r);
        acc_q[2] <= acc_q[2] + SUM_W'(rd_px.g);
        acc_q[3] <= acc_q[3] + SUM_W'(rd_px.b);
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pix_q <= '{a: alpha_in_i, r: red_in_i, g: green_in_i, b: blue_in_i};
            if (t_q == '0) begin
              // sample and clamp geometry for the new frame
              cur_r_q <= (32'(reg_radius_q) > MAX_RADIUS) ?
                         R_W'(MAX_RADIUS) : R_W'(reg_radius_q);
              if (reg_width_q == '0) begin
                cur_w_q <= W_W'(1);
              end else if (32'(reg_width_q) > MAX_WIDTH) begin
                cur_w_q <= W_W'(MAX_WIDTH);
              end else begin
                cur_w_q <= W_W'(reg_width_q);
              end
              if (reg_height_q == '0) begin
                cur_h_q <= H_W'(1);
              end else if (32'(reg_height_q) > MAX_HEIGHT) begin
                cur_h_q <= H_W'(MAX_HEIGHT);
              end else begin
                cur_h_q <= H_W'(reg_height_q);
              end
              state_q <= S_SETUP;
            end else begin
              state_q <= S_PIX;
            end
          end
        end
        S_SETUP: begin
          total_q <= TOT_W'(cur_w_q) * TOT_W'(cur_h_q);
          lag_q   <= T_W'(cur_r_q) * T_W'(cur_w_q) + T_W'(cur_r_q);
          state_q <= S_PIX;
        end
        S_PIX: begin
          // pixel goes into the row window; start a horizontal column if due
          if (in_frame && (k_last || k_ge_r)) begin
            hc_q      <= hc_start;
            row_end_q <= k_last;
            hs_pos_q  <= h_pos;
            hs_ptr_q  <= h_ptr;
            hv_q      <= 1'b0;
            sw_pos_q  <= h_pos;
            sw_ptr_q  <= h_ptr;
            sw_left_q <= {cur_r_q, 1'b0};
            acc_q     <= '0;
            state_q   <= S_SWEEP;
          end else begin
            state_q <= S_VCHK;
          end
        end
        S_SWEEP: begin
          // issue one read a cycle, holding the pointer at a clamped edge
          sw_pos_q  <= pos_next;
          if (adv) begin
            sw_ptr_q <= ptr_inc(sw_ptr_q);
          end
          sw_left_q <= sw_left_q - 1'b1;
          if (sw_left_q == '0) begin
            state_q <= S_SWLAST;
          end
        end
        S_SWLAST: begin
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= hv_q ? S_VOUT : S_HWR;
          end
        end
        S_HWR: begin
          // store the column; at a row end walk on to the last column
          if (row_end_q && (W_W'(hc_q) != cur_w_q - 1'b1)) begin
            hc_q      <= hc_q + 1'b1;
            hs_pos_q  <= hs_pos_q + POS_W'(1);
            sw_pos_q  <= hs_pos_q + POS_W'(1);
            if (!hs_pos_q[POS_W-1]) begin
              hs_ptr_q <= ptr_inc(hs_ptr_q);
              sw_ptr_q <= ptr_inc(hs_ptr_q);
            end else begin
              sw_ptr_q <= hs_ptr_q;
            end
            sw_left_q <= {cur_r_q, 1'b0};
            acc_q     <= '0;
            state_q   <= S_SWEEP;
          end else begin
            state_q <= S_VCHK;
          end
        end
        S_VCHK: begin
          if (emit) begin
            hv_q      <= 1'b1;
            sw_pos_q  <= v_pos;
            sw_ptr_q  <= v_ptr;
            sw_left_q <= {cur_r_q, 1'b0};
            acc_q     <= '0;
            state_q   <= S_SWEEP;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_VOUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_px_q    <= div_quot;
            out_fe_q    <= last_px;
            out_valid_q <= 1'b1;
            state_q     <= S_FIN;
          end
        end
        S_FIN: begin
          // advance frame counters, restart after the last output
          if (emit && last_px) begin
            t_q    <= '0;
            k_q    <= '0;
            wp_q   <= '0;
            rowp_q <= '0;
            x_q    <= '0;
            y_q    <= '0;
            yp_q   <= '0;
            j_q    <= '0;
          end else begin
            t_q <= t_q + 1'b1;
            if (in_frame) begin
              if (k_last) begin
                k_q    <= '0;
                wp_q   <= '0;
                rowp_q <= ptr_inc(rowp_q);
              end else begin
                k_q  <= k_q + 1'b1;
                wp_q <= ptr_inc(wp_q);
              end
            end
            if (emit) begin
              j_q <= j_q + 1'b1;
              if (W_W'(x_q) == cur_w_q - 1'b1) begin
                x_q  <= '0;
                y_q  <= y_q + 1'b1;
                yp_q <= ptr_inc(yp_q);
              end else begin
                x_q <= x_q + 1'b1;
              end
            end
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign alpha_out_o = out_px_q.a;
  assign red_out_o   = out_px_q.r;
  assign green_out_o = out_px_q.g;
  assign blue_out_o  = out_px_q.b;
  assign frame_end_o = out_fe_q;

  // A taken word blocks the input until its work is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // Ring pointers stay inside the kept rows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(sw_ptr_q) < RK) && (32'(hs_ptr_q) < RK) && (32'(yp_q) < RK))
    else $error("ring pointer out of range");

  // Mid-frame the output count stays below the frame size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && (t_q != '0) |-> j_q < total_q)
    else $error("output count overran the frame");

  // The divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider result without a request");

endmodule

// ===== design/sbb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sbb_div.sv =====
// Four-lane restoring divider: one quotient bit per lane each cycle.
module sbb_div import sbb_pkg::*; #(
  parameter int SUM_W = 13,
  parameter int DIV_W = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [3:0][SUM_W-1:0] sum_i,
  input  logic [DIV_W-1:0]      divisor_i,
  output logic                  done_o,
  output px_t                   quot_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIV_W-1:0]      div_q;
  logic [3:0][DIV_W-1:0] rem_q;
  logic [3:0][DIV_W-1:0] rem_d;
  logic [3:0][SUM_W-1:0] quo_q;
  logic [3:0][SUM_W-1:0] quo_d;

  // One restoring step per lane
  always_comb begin
    logic [DIV_W:0] trial;
    logic           ge;
    for (int l = 0; l < 4; l++) begin
      trial    = {rem_q[l], quo_q[l][SUM_W-1]};
      ge       = trial >= {1'b0, div_q};
      rem_d[l] = ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
      quo_d[l] = {quo_q[l][SUM_W-2:0], ge};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (32'(cnt_q) == SUM_W - 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= sum_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o   = done_q;
  assign quot_o.a = quo_q[0][7:0];
  assign quot_o.r = quo_q[1][7:0];
  assign quot_o.g = quo_q[2][7:0];
  assign quot_o.b = quo_q[3][7:0];

endmodule
